// ===== rtl/core/ptlb_pkg.sv =====
// Shared widths, codes and reset values of the prism tetrahedron locator.
package ptlb_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned NumIn     = 9;
  localparam int unsigned InDataW   = NumIn * CoordW;
  localparam int unsigned HeightW   = 31;
  localparam int unsigned TolW      = 48;
  localparam int unsigned CfgDataW  = 48;

  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned ProdW     = 2 * DiffW;
  localparam int unsigned CrossW    = ProdW + 3;
  localparam int unsigned LoW       = 34;
  localparam int unsigned HiW       = CrossW - LoW;
  localparam int unsigned PartW     = HiW + CoordW;
  localparam int unsigned VolW      = 100;
  localparam int unsigned ExtW      = VolW + 4;
  localparam int unsigned AbsW      = VolW - 1;
  localparam int unsigned SumW      = AbsW + 2;

  localparam int unsigned WeightBits = 16;
  localparam int unsigned WeightW    = WeightBits + 1;
  localparam int unsigned OutDataW   = 72;

  localparam logic [WeightW-1:0] WeightOne = WeightW'(1) << WeightBits;

  localparam logic [HeightW-1:0] HeightReset = HeightW'(65536);
  localparam logic [TolW-1:0]    TolReset    = TolW'(1688849860);

  typedef enum logic [0:0] {
    CfgHeight    = 1'b0,
    CfgTolerance = 1'b1
  } cfg_idx_e;

  localparam logic [1:0] TetFirst  = 2'd0;
  localparam logic [1:0] TetSecond = 2'd1;
  localparam logic [1:0] TetThird  = 2'd2;

endpackage

// ===== rtl/core/prism_tet_locate_barycentric.sv =====
// Pipelined locator of a point in a three-tetrahedron triangular prism.
//
// The block takes one beat per clock: a triangle of three uv corners and a
// query point (u, v, height), and returns one beat per input: whether the
// point lies in one of the prism's tetrahedra {0,1,2,4}, {0,2,4,5} or
// {0,3,4,5} (tried in that order), which one, and the four barycentric
// weights in unsigned Q1.16, truncated and saturated at 1.0. It sustains one
// beat per cycle unless the output stalls, with eleven stages of arithmetic
// (corner differences, 33x33 products, planar cross products, split 34-bit
// partial products against the prism height and the query height, the
// signed sub-volumes, their magnitudes, per-tetrahedron sums, the tolerance
// check and the selection) followed by sixteen restoring-division stages,
// one quotient bit per stage for all four weights at once. All six-fold
// volumes are exact; each volume term is a product of the prism height or
// the query height with a planar cross product, so one set of five volume
// terms serves all three tetrahedra. Each stage has its own valid bit and
// ready, so bubbles close up while a finished beat waits on m_axis_tready.
// The user must write the prism height and the volume tolerance through the
// configuration port while the block is idle, which it does not enforce.
module prism_tet_locate_barycentric (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // corner_a_u, corner_a_v, corner_b_u, corner_b_v, corner_c_u, corner_c_v,
  // query_u, query_v, query_h, 32 bits each from the lowest bit up
  input  logic [ptlb_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // found, tet_index, weight_0, weight_1, weight_2, weight_3, zero pad bit
  output logic [ptlb_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [ptlb_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned DivFirst  = 11;
  localparam int unsigned NumStages = DivFirst + ptlb_pkg::WeightBits;
  localparam int unsigned LastDiv   = ptlb_pkg::WeightBits - 1;

  // Magnitude slots: the five product terms and the three combined terms.
  localparam int unsigned MAh = 0;
  localparam int unsigned MBh = 1;
  localparam int unsigned MGh = 2;
  localparam int unsigned MX  = 3;
  localparam int unsigned MD0 = 4;
  localparam int unsigned MD1 = 5;
  localparam int unsigned MD3 = 6;
  localparam int unsigned MTh = 7;

  // Configuration registers; a write while idle applies to the next beat.
  logic [ptlb_pkg::HeightW-1:0] height_q;
  logic [ptlb_pkg::TolW-1:0]    tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= ptlb_pkg::HeightReset;
      tol_q    <= ptlb_pkg::TolReset;
    end else if (cfg_we_i) begin
      case (ptlb_pkg::cfg_idx_e'(cfg_idx_i))
        ptlb_pkg::CfgHeight:    height_q <= cfg_data_i[ptlb_pkg::HeightW-1:0];
        ptlb_pkg::CfgTolerance: tol_q    <= cfg_data_i[ptlb_pkg::TolW-1:0];
        default: ;
      endcase
    end
  end

  // Per-stage flow control. A stage takes a new beat when it is empty or
  // when the stage after it takes its current beat.
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] rdy;

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumStages-1];

  // Stage 0: corner positions relative to the query point.
  logic signed [ptlb_pkg::CoordW-1:0] in_f [ptlb_pkg::NumIn];
  logic signed [ptlb_pkg::DiffW-1:0]  s0_d_d [6];
  logic signed [ptlb_pkg::DiffW-1:0]  s0_d_q [6];
  logic signed [ptlb_pkg::CoordW-1:0] s0_z_q;

  always_comb begin
    for (int i = 0; i < ptlb_pkg::NumIn; i++) begin
      in_f[i] = s_axis_tdata[i*ptlb_pkg::CoordW +: ptlb_pkg::CoordW];
    end
    for (int i = 0; i < 3; i++) begin
      s0_d_d[2*i]   = ptlb_pkg::DiffW'(in_f[2*i])   - ptlb_pkg::DiffW'(in_f[6]);
      s0_d_d[2*i+1] = ptlb_pkg::DiffW'(in_f[2*i+1]) - ptlb_pkg::DiffW'(in_f[7]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_d_q <= s0_d_d;
      s0_z_q <= in_f[8];
    end
  end

  // Stage 1: the six products of the planar cross products.
  // Slots of s0_d_q: 0 au, 1 av, 2 bu, 3 bv, 4 cu, 5 cv.
  logic signed [ptlb_pkg::ProdW-1:0]  s1_p_d [6];
  logic signed [ptlb_pkg::ProdW-1:0]  s1_p_q [6];
  logic signed [ptlb_pkg::CoordW-1:0] s1_z_q;

  always_comb begin
    s1_p_d[0] = ptlb_pkg::ProdW'(s0_d_q[2]) * ptlb_pkg::ProdW'(s0_d_q[5]);
    s1_p_d[1] = ptlb_pkg::ProdW'(s0_d_q[3]) * ptlb_pkg::ProdW'(s0_d_q[4]);
    s1_p_d[2] = ptlb_pkg::ProdW'(s0_d_q[4]) * ptlb_pkg::ProdW'(s0_d_q[1]);
    s1_p_d[3] = ptlb_pkg::ProdW'(s0_d_q[5]) * ptlb_pkg::ProdW'(s0_d_q[0]);
    s1_p_d[4] = ptlb_pkg::ProdW'(s0_d_q[0]) * ptlb_pkg::ProdW'(s0_d_q[3]);
    s1_p_d[5] = ptlb_pkg::ProdW'(s0_d_q[1]) * ptlb_pkg::ProdW'(s0_d_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_p_q <= s1_p_d;
      s1_z_q <= s0_z_q;
    end
  end

  // Stage 2: the planar barycentric numerators alpha, beta and gamma.
  logic signed [ptlb_pkg::CrossW-1:0] s2_c_d [3];
  logic signed [ptlb_pkg::CrossW-1:0] s2_c_q [3];
  logic signed [ptlb_pkg::CoordW-1:0] s2_z_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_c_d[i] = ptlb_pkg::CrossW'(s1_p_q[2*i]) - ptlb_pkg::CrossW'(s1_p_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_c_q <= s2_c_d;
      s2_z_q <= s1_z_q;
    end
  end

  // Stage 3: twice the signed triangle area, the sum of the three numerators.
  logic signed [ptlb_pkg::CrossW-1:0] s3_c_q [4];
  logic signed [ptlb_pkg::CoordW-1:0] s3_z_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_c_q[0] <= s2_c_q[0];
      s3_c_q[1] <= s2_c_q[1];
      s3_c_q[2] <= s2_c_q[2];
      s3_c_q[3] <= s2_c_q[0] + s2_c_q[1] + s2_c_q[2];
      s3_z_q    <= s2_z_q;
    end
  end

  // Stage 4: partial products. Each cross product is split into a signed
  // upper part and an unsigned 34-bit lower part, so no multiplier exceeds
  // about 35 by 32 bits.
  logic signed [ptlb_pkg::PartW-1:0] s4_hh_d [4];
  logic        [ptlb_pkg::PartW-1:0] s4_lh_d [4];
  logic signed [ptlb_pkg::PartW-1:0] s4_hz_d;
  logic signed [ptlb_pkg::PartW-1:0] s4_lz_d;
  logic signed [ptlb_pkg::PartW-1:0] s4_hh_q [4];
  logic        [ptlb_pkg::PartW-1:0] s4_lh_q [4];
  logic signed [ptlb_pkg::PartW-1:0] s4_hz_q;
  logic signed [ptlb_pkg::PartW-1:0] s4_lz_q;

  always_comb begin
    logic signed [ptlb_pkg::HiW-1:0] hi;
    logic        [ptlb_pkg::LoW-1:0] lo;
    logic signed [ptlb_pkg::HiW-1:0] k_hi;
    logic        [ptlb_pkg::LoW-1:0] k_lo;
    for (int i = 0; i < 4; i++) begin
      hi = s3_c_q[i][ptlb_pkg::CrossW-1:ptlb_pkg::LoW];
      lo = s3_c_q[i][ptlb_pkg::LoW-1:0];
      s4_hh_d[i] = ptlb_pkg::PartW'(hi) * ptlb_pkg::PartW'(signed'({1'b0, height_q}));
      s4_lh_d[i] = ptlb_pkg::PartW'(lo) * ptlb_pkg::PartW'(height_q);
    end
    k_hi    = s3_c_q[3][ptlb_pkg::CrossW-1:ptlb_pkg::LoW];
    k_lo    = s3_c_q[3][ptlb_pkg::LoW-1:0];
    s4_hz_d = ptlb_pkg::PartW'(k_hi) * ptlb_pkg::PartW'(s3_z_q);
    s4_lz_d = ptlb_pkg::PartW'(signed'({1'b0, k_lo})) * ptlb_pkg::PartW'(s3_z_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_hh_q <= s4_hh_d;
      s4_lh_q <= s4_lh_d;
      s4_hz_q <= s4_hz_d;
      s4_lz_q <= s4_lz_d;
    end
  end

  // Stage 5: the volume terms alpha*h, beta*h, gamma*h, K*h and z*K.
  logic signed [ptlb_pkg::VolW-1:0] s5_v_d [5];
  logic signed [ptlb_pkg::VolW-1:0] s5_v_q [5];

  always_comb begin
    logic signed [ptlb_pkg::ExtW-1:0] acc;
    for (int i = 0; i < 4; i++) begin
      acc = (ptlb_pkg::ExtW'(s4_hh_q[i]) <<< ptlb_pkg::LoW) + ptlb_pkg::ExtW'(s4_lh_q[i]);
      s5_v_d[i] = acc[ptlb_pkg::VolW-1:0];
    end
    acc = (ptlb_pkg::ExtW'(s4_hz_q) <<< ptlb_pkg::LoW) + ptlb_pkg::ExtW'(s4_lz_q);
    s5_v_d[4] = acc[ptlb_pkg::VolW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) s5_v_q <= s5_v_d;
  end

  // Stage 6: the signed sub-volumes that mix the two heights.
  logic signed [ptlb_pkg::VolW-1:0] s6_t_q [8];

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s6_t_q[MAh] <= s5_v_q[0];
      s6_t_q[MBh] <= s5_v_q[1];
      s6_t_q[MGh] <= s5_v_q[2];
      s6_t_q[MX]  <= s5_v_q[4];
      s6_t_q[MD0] <= s5_v_q[1] - s5_v_q[4];
      s6_t_q[MD1] <= s5_v_q[3] - s5_v_q[0] - s5_v_q[4];
      s6_t_q[MD3] <= s5_v_q[3] - s5_v_q[4];
      s6_t_q[MTh] <= s5_v_q[3];
    end
  end

  // Stage 7: magnitudes.
  logic [ptlb_pkg::AbsW-1:0] s7_m_d [8];
  logic [ptlb_pkg::AbsW-1:0] s7_m_q [8];

  always_comb begin
    logic signed [ptlb_pkg::VolW-1:0] mag;
    for (int i = 0; i < 8; i++) begin
      mag = s6_t_q[i][ptlb_pkg::VolW-1] ? -s6_t_q[i] : s6_t_q[i];
      s7_m_d[i] = mag[ptlb_pkg::AbsW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) s7_m_q <= s7_m_d;
  end

  // Stage 8: sum of the four sub-volume magnitudes of each tetrahedron.
  logic [ptlb_pkg::SumW-1:0] s8_s_q [3];
  logic [ptlb_pkg::AbsW-1:0] s8_m_q [8];

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      s8_s_q[0] <= ptlb_pkg::SumW'(s7_m_q[MAh]) + ptlb_pkg::SumW'(s7_m_q[MD0])
                 + ptlb_pkg::SumW'(s7_m_q[MGh]) + ptlb_pkg::SumW'(s7_m_q[MX]);
      s8_s_q[1] <= ptlb_pkg::SumW'(s7_m_q[MAh]) + ptlb_pkg::SumW'(s7_m_q[MD1])
                 + ptlb_pkg::SumW'(s7_m_q[MBh]) + ptlb_pkg::SumW'(s7_m_q[MD0]);
      s8_s_q[2] <= ptlb_pkg::SumW'(s7_m_q[MD3]) + ptlb_pkg::SumW'(s7_m_q[MD1])
                 + ptlb_pkg::SumW'(s7_m_q[MBh]) + ptlb_pkg::SumW'(s7_m_q[MGh]);
      s8_m_q    <= s7_m_q;
    end
  end

  // Stage 9: excess of each sum over the total volume; the sum of magnitudes
  // never falls below the total, so the excess is never negative.
  logic [ptlb_pkg::SumW-1:0] s9_e_q [3];
  logic                      s9_nz_q;
  logic [ptlb_pkg::AbsW-1:0] s9_m_q [8];

  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      for (int i = 0; i < 3; i++) begin
        s9_e_q[i] <= s8_s_q[i] - ptlb_pkg::SumW'(s8_m_q[MTh]);
      end
      s9_nz_q <= (s8_m_q[MTh] != '0);
      s9_m_q  <= s8_m_q;
    end
  end

  // Stage 10: tolerance check and choice of the first tetrahedron that holds
  // the point. A degenerate prism holds nothing.
  logic                      s10_fnd_d;
  logic [1:0]                s10_tet_d;
  logic [ptlb_pkg::AbsW-1:0] s10_v_d [4];
  logic                      s10_fnd_q;
  logic [1:0]                s10_tet_q;
  logic [ptlb_pkg::AbsW-1:0] s10_v_q [4];
  logic [ptlb_pkg::AbsW-1:0] s10_t_q;

  always_comb begin
    logic [2:0] hit;
    for (int i = 0; i < 3; i++) begin
      hit[i] = s9_nz_q && (s9_e_q[i] < ptlb_pkg::SumW'(tol_q));
    end
    s10_fnd_d = 1'b1;
    s10_tet_d = ptlb_pkg::TetFirst;
    s10_v_d   = '{default: '0};
    if (hit[0]) begin
      s10_v_d = '{s9_m_q[MAh], s9_m_q[MD0], s9_m_q[MGh], s9_m_q[MX]};
    end else if (hit[1]) begin
      s10_tet_d = ptlb_pkg::TetSecond;
      s10_v_d   = '{s9_m_q[MAh], s9_m_q[MD1], s9_m_q[MBh], s9_m_q[MD0]};
    end else if (hit[2]) begin
      s10_tet_d = ptlb_pkg::TetThird;
      s10_v_d   = '{s9_m_q[MD3], s9_m_q[MD1], s9_m_q[MBh], s9_m_q[MGh]};
    end else begin
      s10_fnd_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[10]) begin
      s10_fnd_q <= s10_fnd_d;
      s10_tet_q <= s10_tet_d;
      s10_v_q   <= s10_v_d;
      s10_t_q   <= s9_m_q[MTh];
    end
  end

  // Stages 11 to 26: restoring division, one quotient bit per stage for
  // all four weights. A sub-volume not below the total saturates to 1.0.
  logic [ptlb_pkg::AbsW-1:0]       dv_rem_q [LastDiv][4];
  logic [ptlb_pkg::WeightBits-1:0] dv_quo_q [ptlb_pkg::WeightBits][4];
  logic [3:0]                      dv_sat_q [ptlb_pkg::WeightBits];
  logic [ptlb_pkg::AbsW-1:0]       dv_tot_q [ptlb_pkg::WeightBits];
  logic                            dv_fnd_q [ptlb_pkg::WeightBits];
  logic [1:0]                      dv_tet_q [ptlb_pkg::WeightBits];

  for (genvar j = 0; j < ptlb_pkg::WeightBits; j++) begin : g_div
    logic [ptlb_pkg::AbsW-1:0]       rem_src [4];
    logic [ptlb_pkg::WeightBits-1:0] quo_src [4];
    logic [3:0]                      sat_src;
    logic [ptlb_pkg::AbsW-1:0]       tot_src;
    logic                            fnd_src;
    logic [1:0]                      tet_src;
    logic [ptlb_pkg::AbsW-1:0]       rem_d [4];
    logic [ptlb_pkg::WeightBits-1:0] quo_d [4];

    if (j == 0) begin : g_src
      always_comb begin
        for (int i = 0; i < 4; i++) begin
          rem_src[i] = s10_v_q[i];
          quo_src[i] = '0;
          sat_src[i] = (s10_v_q[i] >= s10_t_q);
        end
        tot_src = s10_t_q;
        fnd_src = s10_fnd_q;
        tet_src = s10_tet_q;
      end
    end else begin : g_src
      always_comb begin
        for (int i = 0; i < 4; i++) begin
          rem_src[i] = dv_rem_q[j-1][i];
          quo_src[i] = dv_quo_q[j-1][i];
        end
        sat_src = dv_sat_q[j-1];
        tot_src = dv_tot_q[j-1];
        fnd_src = dv_fnd_q[j-1];
        tet_src = dv_tet_q[j-1];
      end
    end

    always_comb begin
      logic [ptlb_pkg::AbsW:0] r2;
      logic [ptlb_pkg::AbsW:0] rs;
      for (int i = 0; i < 4; i++) begin
        r2 = {rem_src[i], 1'b0};
        rs = r2 - {1'b0, tot_src};
        if (r2 >= {1'b0, tot_src}) begin
          rem_d[i] = rs[ptlb_pkg::AbsW-1:0];
          quo_d[i] = {quo_src[i][ptlb_pkg::WeightBits-2:0], 1'b1};
        end else begin
          rem_d[i] = r2[ptlb_pkg::AbsW-1:0];
          quo_d[i] = {quo_src[i][ptlb_pkg::WeightBits-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[DivFirst+j]) begin
        dv_quo_q[j] <= quo_d;
        dv_sat_q[j] <= sat_src;
        dv_tot_q[j] <= tot_src;
        dv_fnd_q[j] <= fnd_src;
        dv_tet_q[j] <= tet_src;
      end
    end

    if (j != LastDiv) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (rdy[DivFirst+j]) dv_rem_q[j] <= rem_d;
      end
    end
  end

  // Output beat.
  logic [ptlb_pkg::WeightW-1:0] weight [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!dv_fnd_q[LastDiv]) begin
        weight[i] = '0;
      end else if (dv_sat_q[LastDiv][i]) begin
        weight[i] = ptlb_pkg::WeightOne;
      end else begin
        weight[i] = {1'b0, dv_quo_q[LastDiv][i]};
      end
    end
  end

  assign m_axis_tdata = {1'b0, weight[3], weight[2], weight[1], weight[0],
                         dv_tet_q[LastDiv], dv_fnd_q[LastDiv]};

endmodule
